// ===== src/epgds_pkg.sv =====
// Shared types, codes and helpers of the discrete order shift block.
package epgds_pkg;

	localparam int VAL_W = 64;
	localparam int STEP_W = 21;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_FINISH = 2'd1,
		ACT_READ   = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		KIND_F  = 2'd0,
		KIND_FS = 2'd1,
		KIND_Z  = 2'd2
	} kind_t;

	typedef struct packed {
		act_t               action;
		logic [19:0]        order;
		logic               pool;
		logic               echo_row;
		logic signed [31:0] f_re;
		logic signed [31:0] f_im;
		logic signed [31:0] fs_re;
		logic signed [31:0] fs_im;
		logic signed [31:0] z_re;
		logic signed [31:0] z_im;
		logic [9:0]         index;
	} req_t;

	typedef struct packed {
		logic [19:0]        out_order;
		logic signed [31:0] out_f_re;
		logic signed [31:0] out_f_im;
		logic signed [31:0] out_fs_re;
		logic signed [31:0] out_fs_im;
		logic signed [31:0] out_z_re;
		logic signed [31:0] out_z_im;
		logic [10:0]        entry_count;
		logic               overflow;
	} res_t;

	// complex conjugate, re in low half, im in high half; -(-2^31) saturates
	function automatic logic [VAL_W-1:0] conj(input logic [VAL_W-1:0] v);
		logic [31:0] im;
		im = v[63:32];
		if (im == 32'h8000_0000) begin
			im = 32'h7FFF_FFFF;
		end else begin
			im = 32'(~im + 32'd1);
		end
		return {im, v[31:0]};
	endfunction

endpackage

// ===== src/epgds_if.sv =====
// Request and response channel interfaces.
interface epgds_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [19:0]        order;
	logic               pool;
	logic               echo_row;
	logic signed [31:0] f_re;
	logic signed [31:0] f_im;
	logic signed [31:0] fs_re;
	logic signed [31:0] fs_im;
	logic signed [31:0] z_re;
	logic signed [31:0] z_im;
	logic [9:0]         index;

	modport source (output valid, action, order, pool, echo_row, f_re, f_im, fs_re, fs_im,
		z_re, z_im, index, input ready);
	modport sink (input valid, action, order, pool, echo_row, f_re, f_im, fs_re, fs_im,
		z_re, z_im, index, output ready);
endinterface

interface epgds_rsp_if;
	logic               valid;
	logic               ready;
	logic [19:0]        out_order;
	logic signed [31:0] out_f_re;
	logic signed [31:0] out_f_im;
	logic signed [31:0] out_fs_re;
	logic signed [31:0] out_fs_im;
	logic signed [31:0] out_z_re;
	logic signed [31:0] out_z_im;
	logic [10:0]        entry_count;
	logic               overflow;

	modport source (output valid, out_order, out_f_re, out_f_im, out_fs_re, out_fs_im,
		out_z_re, out_z_im, entry_count, overflow, input ready);
	modport sink (input valid, out_order, out_f_re, out_f_im, out_fs_re, out_fs_im,
		out_z_re, out_z_im, entry_count, overflow, output ready);
endinterface

// ===== src/epg_discrete_order_shift_core.sv =====
// Top level of the discrete phase-graph order shift block.
//
// Channels: req (sink) takes load, finish, read and no-op transactions; rsp
// (source) returns exactly one result per request, in order. The order step
// is written over the APB port at byte address 0; the user must write it
// only while idle, the block does not enforce it. Each target of a load
// (each non-zero value, or with a zero step the row of its order) is found
// by scanning the order memory one entry a cycle; its value row is then read
// or zeroed, patched and written back. A load makes up to three writes; an
// echo row first resets the table to one cleared row. Finish rebuilds row 0
// unless the step is zero. The lookup scan over the order memory sets the
// throughput. After reset an init state writes location 0 (order zero, zero
// values) before the first request is taken. A stalled receiver holds the
// result in the output register; the block still accepts and works on the
// next request and waits only when that one is done before rsp is free.
module epg_discrete_order_shift_core #(
	parameter int TABLE_DEPTH = 1024,
	parameter int POOL_COUNT  = 2,
	parameter int ORDER_BITS  = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	epgds_req_if.sink   req,
	epgds_rsp_if.source rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import epgds_pkg::*;

	logic [STEP_W-1:0] shift_amount;
	req_t              req_d;
	res_t              res_d;
	res_t              out_q;
	logic              out_vld_q;
	logic              res_valid;
	logic              res_take;

	epgds_apb u_apb (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.shift_amount (shift_amount)
	);

	always_comb begin
		req_d.action   = act_t'(req.action);
		req_d.order    = req.order;
		req_d.pool     = req.pool;
		req_d.echo_row = req.echo_row;
		req_d.f_re     = req.f_re;
		req_d.f_im     = req.f_im;
		req_d.fs_re    = req.fs_re;
		req_d.fs_im    = req.fs_im;
		req_d.z_re     = req.z_re;
		req_d.z_im     = req.z_im;
		req_d.index    = req.index;
	end

	epgds_engine #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.POOL_COUNT  (POOL_COUNT),
		.ORDER_BITS  (ORDER_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.shift_amount (shift_amount),
		.req_valid    (req.valid),
		.req_ready    (req.ready),
		.req          (req_d),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res_d)
	);

	assign res_take = res_valid && (!out_vld_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res_d;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.out_order   = out_q.out_order;
	assign rsp.out_f_re    = out_q.out_f_re;
	assign rsp.out_f_im    = out_q.out_f_im;
	assign rsp.out_fs_re   = out_q.out_fs_re;
	assign rsp.out_fs_im   = out_q.out_fs_im;
	assign rsp.out_z_re    = out_q.out_z_re;
	assign rsp.out_z_im    = out_q.out_z_im;
	assign rsp.entry_count = out_q.entry_count;
	assign rsp.overflow    = out_q.overflow;
endmodule

// ===== src/epgds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module epgds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/epgds_apb.sv =====
// APB configuration register holding the signed order step.
module epgds_apb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [epgds_pkg::STEP_W-1:0] shift_amount
);
	import epgds_pkg::*;

	localparam logic [2:0] ADDR_SHIFT = 3'd0;

	logic [STEP_W-1:0] shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (psel && penable && pwrite && paddr == ADDR_SHIFT) begin
			shift_q <= pwdata[STEP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign shift_amount = shift_q;
	assign prdata = (paddr == ADDR_SHIFT) ? {{(32-STEP_W){shift_q[STEP_W-1]}}, shift_q} : '0;
endmodule

// ===== src/epgds_engine.sv =====
// Sequencer: order lookup by scan of the order memory, row read-modify-write.
module epgds_engine #(
	parameter int TABLE_DEPTH = 1024,
	parameter int POOL_COUNT  = 2,
	parameter int ORDER_BITS  = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [epgds_pkg::STEP_W-1:0] shift_amount,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  epgds_pkg::req_t              req,
	output logic                         res_valid,
	input  logic                         res_take,
	output epgds_pkg::res_t              res
);
	import epgds_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;
	localparam int RW = POOL_COUNT * 3 * VAL_W;
	localparam int TW = ((ORDER_BITS > STEP_W) ? ORDER_BITS : STEP_W) + 2;
	localparam logic [ORDER_BITS-1:0] ORD_MAX = '1;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	typedef enum logic [7:0] {
		ST_INIT = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_CLR  = 8'b0000_0100,
		ST_NXT  = 8'b0000_1000,
		ST_SCAN = 8'b0001_0000,
		ST_VRD  = 8'b0010_0000,
		ST_VWR  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} st_t;

	st_t                   st_q;
	logic [CW-1:0]         used_q;
	logic                  ovf_q;
	logic [2:0]            op_vld_q;
	logic [ORDER_BITS-1:0] op_ord_q [3];
	kind_t                 op_kind_q [3];
	logic [VAL_W-1:0]      op_val_q [3];
	logic                  all_q;
	logic                  fin_q;
	logic                  alloc_q;
	logic                  pool_q;
	logic [AW-1:0]         loc_q;
	logic [CW-1:0]         scan_q;
	logic                  vld_s1;
	logic [AW-1:0]         addr_s1;
	logic                  rd_q;
	logic                  rd_ok_q;
	logic                  rd_pool_ok_q;
	logic [19:0]           res_ord_q;
	logic [VAL_W-1:0]      res_f_q;
	logic [VAL_W-1:0]      res_fs_q;
	logic [VAL_W-1:0]      res_z_q;

	logic                  ord_we;
	logic [AW-1:0]         ord_waddr;
	logic [AW-1:0]         ord_raddr;
	logic [ORDER_BITS-1:0] ord_rdata;
	logic                  val_we;
	logic [AW-1:0]         val_waddr;
	logic [RW-1:0]         val_wdata;
	logic [AW-1:0]         val_raddr;
	logic [RW-1:0]         val_rdata;

	logic                  step0;
	logic [ORDER_BITS-1:0] k;
	logic [TW-1:0]         k_x;
	logic [TW-1:0]         step_x;
	logic [TW-1:0]         t_f;
	logic [TW-1:0]         t_s;
	logic [TW-1:0]         mag_f;
	logic [TW-1:0]         mag_s;
	logic                  neg_f;
	logic                  neg_s;
	logic                  sat_f;
	logic                  sat_s;
	logic [ORDER_BITS-1:0] ord_f;
	logic [ORDER_BITS-1:0] ord_s;
	logic [VAL_W-1:0]      fv;
	logic [VAL_W-1:0]      fsv;
	logic [VAL_W-1:0]      zv;
	logic                  pool_ok;
	logic [2:0]            new_vld;
	logic [1:0]            cur;
	logic                  scan_more;
	logic                  hit;
	logic [RW-1:0]         row_base;
	logic [RW-1:0]         row_new;
	int                    ps;
	int                    rps;

	epgds_ram #(.WIDTH(ORDER_BITS), .DEPTH(TABLE_DEPTH)) u_ord_mem (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (st_q == ST_INIT ? '0 : op_ord_q[cur]),
		.raddr (ord_raddr),
		.rdata (ord_rdata)
	);

	epgds_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_val_mem (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// target orders of the incoming row
	always_comb begin
		step0   = (shift_amount == '0);
		k       = req.echo_row ? '0 : ORDER_BITS'(req.order);
		k_x     = {{(TW-ORDER_BITS){1'b0}}, k};
		step_x  = {{(TW-STEP_W){shift_amount[STEP_W-1]}}, shift_amount};
		t_f     = k_x + step_x;
		t_s     = k_x - step_x;
		neg_f   = t_f[TW-1];
		neg_s   = t_s[TW-1];
		mag_f   = neg_f ? TW'(~t_f + 1'b1) : t_f;
		mag_s   = neg_s ? TW'(~t_s + 1'b1) : t_s;
		sat_f   = mag_f > {{(TW-ORDER_BITS){1'b0}}, ORD_MAX};
		sat_s   = mag_s > {{(TW-ORDER_BITS){1'b0}}, ORD_MAX};
		ord_f   = sat_f ? ORD_MAX : mag_f[ORDER_BITS-1:0];
		ord_s   = sat_s ? ORD_MAX : mag_s[ORDER_BITS-1:0];
		fv      = {req.f_im, req.f_re};
		fsv     = {req.fs_im, req.fs_re};
		zv      = {req.z_im, req.z_re};
		pool_ok = (int'(req.pool) < POOL_COUNT);
		new_vld[0] = pool_ok && (step0 || zv != '0);
		new_vld[1] = pool_ok && !step0 && fv != '0;
		new_vld[2] = pool_ok && !step0 && !req.echo_row && fsv != '0;
	end

	always_comb begin
		priority if (op_vld_q[0]) begin
			cur = 2'd0;
		end else if (op_vld_q[1]) begin
			cur = 2'd1;
		end else begin
			cur = 2'd2;
		end
	end

	assign scan_more = scan_q < used_q;
	assign hit       = vld_s1 && ord_rdata == op_ord_q[cur];

	assign req_ready = (st_q == ST_IDLE);
	assign res_valid = (st_q == ST_DONE);

	assign ord_raddr = (st_q == ST_SCAN) ? scan_q[AW-1:0] : AW'(req.index);
	assign ord_we    = (st_q == ST_INIT) ||
		(st_q == ST_SCAN && !hit && !scan_more && !vld_s1 && used_q != DEPTH_C);
	assign ord_waddr = (st_q == ST_INIT) ? '0 : used_q[AW-1:0];

	assign val_raddr = (st_q == ST_VRD) ? loc_q : AW'(req.index);
	assign val_we    = (st_q == ST_INIT) || (st_q == ST_CLR) || (st_q == ST_VWR);
	assign val_waddr = (st_q == ST_VWR) ? loc_q : '0;
	assign val_wdata = (st_q == ST_VWR) ? row_new : '0;

	// row patch: finish rebuilds the echo pair, a load writes its slot(s)
	always_comb begin
		ps       = (int'(pool_q) < POOL_COUNT) ? int'(pool_q) : 0;
		row_base = alloc_q ? '0 : val_rdata;
		row_new  = row_base;
		if (fin_q) begin
			for (int p = 0; p < POOL_COUNT; p++) begin
				if (row_base[(p*3+int'(KIND_F))*VAL_W +: VAL_W] != '0) begin
					row_new[(p*3+int'(KIND_FS))*VAL_W +: VAL_W] =
						conj(row_base[(p*3+int'(KIND_F))*VAL_W +: VAL_W]);
				end else if (row_base[(p*3+int'(KIND_FS))*VAL_W +: VAL_W] != '0) begin
					row_new[(p*3+int'(KIND_F))*VAL_W +: VAL_W] =
						conj(row_base[(p*3+int'(KIND_FS))*VAL_W +: VAL_W]);
				end
			end
		end else if (all_q) begin
			row_new[(ps*3+int'(KIND_Z))*VAL_W +: VAL_W]  = op_val_q[0];
			row_new[(ps*3+int'(KIND_F))*VAL_W +: VAL_W]  = op_val_q[1];
			row_new[(ps*3+int'(KIND_FS))*VAL_W +: VAL_W] = op_val_q[2];
		end else begin
			row_new[(ps*3+int'(op_kind_q[cur]))*VAL_W +: VAL_W] = op_val_q[cur];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_INIT;
			used_q   <= CW'(1);
			ovf_q    <= 1'b0;
			op_vld_q <= '0;
			vld_s1   <= 1'b0;
			fin_q    <= 1'b0;
			alloc_q  <= 1'b0;
			rd_q     <= 1'b0;
		end else begin
			unique case (st_q)
				ST_INIT: begin
					st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) begin
						alloc_q <= 1'b0;
						unique case (req.action)
							ACT_LOAD: begin
								fin_q    <= 1'b0;
								rd_q     <= 1'b0;
								op_vld_q <= new_vld;
								all_q    <= step0;
								if (req.echo_row) begin
									used_q <= CW'(1);
									ovf_q  <= (new_vld[1] && sat_f) || (new_vld[2] && sat_s);
									st_q   <= ST_CLR;
								end else begin
									ovf_q <= ovf_q || (new_vld[1] && sat_f) ||
										(new_vld[2] && sat_s);
									st_q  <= ST_NXT;
								end
							end
							ACT_FINISH: begin
								rd_q  <= 1'b0;
								fin_q <= !step0;
								st_q  <= step0 ? ST_DONE : ST_VRD;
							end
							ACT_READ: begin
								fin_q <= 1'b0;
								rd_q  <= 1'b1;
								st_q  <= ST_DONE;
							end
							default: begin
								fin_q <= 1'b0;
								rd_q  <= 1'b0;
								st_q  <= ST_DONE;
							end
						endcase
					end
				end
				ST_CLR: begin
					st_q <= ST_NXT;
				end
				ST_NXT: begin
					scan_q <= '0;
					vld_s1 <= 1'b0;
					st_q   <= (op_vld_q != '0) ? ST_SCAN : ST_DONE;
				end
				ST_SCAN: begin
					priority if (hit) begin
						alloc_q <= 1'b0;
						st_q    <= ST_VRD;
					end else if (!scan_more && !vld_s1) begin
						if (used_q == DEPTH_C) begin
							ovf_q         <= 1'b1;
							op_vld_q[cur] <= 1'b0;
							st_q          <= ST_NXT;
						end else begin
							used_q  <= used_q + 1'b1;
							alloc_q <= 1'b1;
							st_q    <= ST_VWR;
						end
					end else begin
						vld_s1 <= scan_more;
						if (scan_more) begin
							scan_q <= scan_q + 1'b1;
						end
					end
				end
				ST_VRD: begin
					st_q <= ST_VWR;
				end
				ST_VWR: begin
					op_vld_q[cur] <= 1'b0;
					alloc_q       <= 1'b0;
					st_q          <= fin_q ? ST_DONE : ST_NXT;
				end
				ST_DONE: begin
					rd_q <= 1'b0;
					if (res_take) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_INIT;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && req_valid) begin
			pool_q       <= req.pool;
			loc_q        <= '0;
			op_ord_q[0]  <= k;
			op_kind_q[0] <= KIND_Z;
			op_val_q[0]  <= zv;
			op_ord_q[1]  <= ord_f;
			op_kind_q[1] <= neg_f ? KIND_FS : KIND_F;
			op_val_q[1]  <= neg_f ? conj(fv) : fv;
			op_ord_q[2]  <= ord_s;
			op_kind_q[2] <= neg_s ? KIND_F : KIND_FS;
			op_val_q[2]  <= neg_s ? conj(fsv) : fsv;
			rd_ok_q      <= (32'(req.index) < 32'(used_q)) &&
				(32'(req.index) < 32'(TABLE_DEPTH));
			rd_pool_ok_q <= pool_ok;
		end
		if (st_q == ST_SCAN) begin
			addr_s1 <= scan_q[AW-1:0];
			if (hit) begin
				loc_q <= addr_s1;
			end else if (!scan_more && !vld_s1) begin
				loc_q <= used_q[AW-1:0];
			end
		end
	end

	// read data arrives the cycle after acceptance
	always_comb begin
		rps = (int'(pool_q) < POOL_COUNT) ? int'(pool_q) : 0;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && req_valid) begin
			res_ord_q <= '0;
			res_f_q   <= '0;
			res_fs_q  <= '0;
			res_z_q   <= '0;
		end else if (rd_q && st_q == ST_DONE) begin
			if (rd_ok_q) begin
				res_ord_q <= 20'(ord_rdata);
			end
			if (rd_ok_q && rd_pool_ok_q) begin
				res_f_q  <= val_rdata[(rps*3+int'(KIND_F))*VAL_W +: VAL_W];
				res_fs_q <= val_rdata[(rps*3+int'(KIND_FS))*VAL_W +: VAL_W];
				res_z_q  <= val_rdata[(rps*3+int'(KIND_Z))*VAL_W +: VAL_W];
			end
		end
	end

	function automatic logic [31:0] rd_val(input kind_t kd, input logic hi);
		logic [VAL_W-1:0] v;
		v = val_rdata[(rps*3+int'(kd))*VAL_W +: VAL_W];
		if (!(rd_ok_q && rd_pool_ok_q)) begin
			v = '0;
		end
		return hi ? v[63:32] : v[31:0];
	endfunction

	assign res.out_order   = rd_q ? (rd_ok_q ? 20'(ord_rdata) : '0) : res_ord_q;
	assign res.out_f_re    = rd_q ? rd_val(KIND_F, 1'b0) : res_f_q[31:0];
	assign res.out_f_im    = rd_q ? rd_val(KIND_F, 1'b1) : res_f_q[63:32];
	assign res.out_fs_re   = rd_q ? rd_val(KIND_FS, 1'b0) : res_fs_q[31:0];
	assign res.out_fs_im   = rd_q ? rd_val(KIND_FS, 1'b1) : res_fs_q[63:32];
	assign res.out_z_re    = rd_q ? rd_val(KIND_Z, 1'b0) : res_z_q[31:0];
	assign res.out_z_im    = rd_q ? rd_val(KIND_Z, 1'b1) : res_z_q[63:32];
	assign res.entry_count = 11'(used_q);
	assign res.overflow    = ovf_q;

	as_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q >= CW'(1) && used_q <= DEPTH_C)
		else $error("entry count out of range");
	as_ord_write: assert property (@(posedge clk) disable iff (!arst_n)
		ord_we |-> (st_q == ST_INIT || st_q == ST_SCAN))
		else $error("order memory written outside lookup");
	as_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SCAN |-> scan_q <= used_q)
		else $error("scan ran past the used entries");
	as_done_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && res_take) |=> st_q == ST_IDLE)
		else $error("result handed over but sequencer not idle");
	as_alloc_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_VWR && alloc_q) |-> used_q == $past(used_q) + 1'b1)
		else $error("new location without entry count increment");
endmodule

// ===== tb/tb_epg_discrete_order_shift_core.sv =====
// Self-checking testbench of the discrete phase-graph order shift core.
module tb_epg_discrete_order_shift_core;
	import epgds_pkg::*;

	localparam int DEPTH = 1024;
	localparam int NPOOL = 2;
	localparam logic [19:0] ORD_MAX = 20'hF_FFFF;
	localparam int N_ITEMS = 1450;
	localparam int CALM_AT = 1250;
	localparam int WDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 200;

	typedef struct {
		logic signed [20:0] stp;
		req_t               r;
		bit                 typed;
		res_t               exp;
	} drow_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	epgds_req_if req_ch();
	epgds_rsp_if rsp_ch();

	epg_discrete_order_shift_core dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// shift state of the predictor
	logic [19:0] ord_tab [DEPTH];
	logic [63:0] val_tab [DEPTH][NPOOL][3];
	int unsigned used_n;
	bit ovf;
	logic signed [20:0] step_q;

	res_t shifted_q [$];
	int fail_count = 0;
	int sent = 0;
	int got = 0;
	bit calm = 0;
	bit held = 0;
	int hold_n = 0;
	int stall = 0;
	int idle_cycles = 0;

	function automatic logic [63:0] conj_c(logic [63:0] v);
		logic [31:0] im;
		im = v[63:32];
		im = (im == 32'h8000_0000) ? 32'h7FFF_FFFF : -im;
		return {im, v[31:0]};
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < DEPTH; i++) begin
			ord_tab[i] = '0;
			for (int p = 0; p < NPOOL; p++) begin
				for (int k = 0; k < 3; k++) val_tab[i][p][k] = '0;
			end
		end
		used_n = 1;
		ovf = 0;
	endfunction

	function automatic int locate(logic [19:0] o);
		for (int i = 0; i < used_n; i++) begin
			if (ord_tab[i] == o) return i;
		end
		if (used_n >= DEPTH) begin
			ovf = 1;
			return -1;
		end
		ord_tab[used_n] = o;
		used_n++;
		return used_n - 1;
	endfunction

	function automatic logic [19:0] fold_ord(longint t, output bit neg);
		longint mag;
		neg = t < 0;
		mag = neg ? -t : t;
		if (mag > longint'(ORD_MAX)) begin
			mag = longint'(ORD_MAX);
			ovf = 1;
		end
		return 20'(mag);
	endfunction

	function automatic void put_val(logic [19:0] o, int p, kind_t kd, logic [63:0] v);
		int loc;
		loc = locate(o);
		if (loc >= 0) val_tab[loc][p][kd] = v;
	endfunction

	function automatic res_t shift_predict(req_t r);
		res_t o;
		logic [19:0] k, t;
		logic [63:0] fv, fsv, zv;
		bit neg;
		int loc, p;
		o = '0;
		p = r.pool;
		fv = {r.f_im, r.f_re};
		fsv = {r.fs_im, r.fs_re};
		zv = {r.z_im, r.z_re};
		case (r.action)
			ACT_LOAD: begin
				if (r.echo_row) clear_table();
				k = r.echo_row ? 20'd0 : r.order;
				if (step_q == 0) begin
					loc = locate(k);
					if (loc >= 0) begin
						val_tab[loc][p][KIND_F] = fv;
						val_tab[loc][p][KIND_FS] = fsv;
						val_tab[loc][p][KIND_Z] = zv;
					end
				end else begin
					if (zv != 0) put_val(k, p, KIND_Z, zv);
					if (fv != 0) begin
						t = fold_ord(longint'(k) + longint'(step_q), neg);
						put_val(t, p, neg ? KIND_FS : KIND_F, neg ? conj_c(fv) : fv);
					end
					if (!r.echo_row && fsv != 0) begin
						t = fold_ord(longint'(k) - longint'(step_q), neg);
						put_val(t, p, neg ? KIND_F : KIND_FS, neg ? conj_c(fsv) : fsv);
					end
				end
			end
			ACT_FINISH: begin
				if (step_q != 0) begin
					for (int q = 0; q < NPOOL; q++) begin
						if (val_tab[0][q][KIND_F] != 0)
							val_tab[0][q][KIND_FS] = conj_c(val_tab[0][q][KIND_F]);
						else if (val_tab[0][q][KIND_FS] != 0)
							val_tab[0][q][KIND_F] = conj_c(val_tab[0][q][KIND_FS]);
					end
				end
			end
			ACT_READ: begin
				if (r.index < used_n) begin
					o.out_order = ord_tab[r.index];
					{o.out_f_im, o.out_f_re} = val_tab[r.index][p][KIND_F];
					{o.out_fs_im, o.out_fs_re} = val_tab[r.index][p][KIND_FS];
					{o.out_z_im, o.out_z_re} = val_tab[r.index][p][KIND_Z];
				end
			end
			default: ;
		endcase
		o.entry_count = 11'(used_n);
		o.overflow = ovf;
		return o;
	endfunction

	function automatic req_t mk_req(act_t a, logic [19:0] o, logic pl, logic e,
		logic [63:0] f, logic [63:0] fs, logic [63:0] z, logic [9:0] idx);
		req_t r;
		r.action = a;
		r.order = o;
		r.pool = pl;
		r.echo_row = e;
		{r.f_im, r.f_re} = f;
		{r.fs_im, r.fs_re} = fs;
		{r.z_im, r.z_re} = z;
		r.index = idx;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [63:0] rand_cplx();
		if ($urandom_range(0, 2) == 0) return 64'h0;
		return {rand_word(), rand_word()};
	endfunction

	function automatic logic [19:0] rand_order();
		if ($urandom_range(0, 7) == 0) return 20'($urandom);
		return 20'($urandom_range(0, 63));
	endfunction

	task automatic send_req(req_t r, bit typed = 0, res_t exp = '0);
		res_t pr;
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= r.action;
		req_ch.order <= r.order;
		req_ch.pool <= r.pool;
		req_ch.echo_row <= r.echo_row;
		req_ch.f_re <= r.f_re;
		req_ch.f_im <= r.f_im;
		req_ch.fs_re <= r.fs_re;
		req_ch.fs_im <= r.fs_im;
		req_ch.z_re <= r.z_re;
		req_ch.z_im <= r.z_im;
		req_ch.index <= r.index;
		do @(posedge clk); while (!req_ch.ready);
		pr = shift_predict(r);
		shifted_q.push_back(typed ? exp : pr);
		sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (shifted_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_step(logic signed [20:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= {{11{v[20]}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		step_q = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic signed [20:0] rand_step();
		logic signed [20:0] s;
		case ($urandom_range(0, 6))
			0: s = 0;
			1: s = 1;
			2: s = -1;
			3: s = 21'sd1048575;
			4: s = -21'sd1048575;
			5: begin
				s = 21'($urandom_range(1, 40));
				if ($urandom_range(0, 1)) s = -s;
			end
			default: begin
				s = 21'($urandom);
				if (s == 21'h10_0000) s = 0;
			end
		endcase
		return s;
	endfunction

	task automatic run_pass();
		int n;
		if ($urandom_range(0, 5) == 0)
			send_req(mk_req(ACT_LOAD, rand_order(), 1'($urandom), 0, rand_cplx(), rand_cplx(),
				rand_cplx(), 10'($urandom)));
		send_req(mk_req(ACT_LOAD, 20'($urandom), 1'($urandom), 1, rand_cplx(), rand_cplx(),
			rand_cplx(), 10'($urandom)));
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: send_req(mk_req(ACT_NONE, 20'($urandom), 1'($urandom), 1'($urandom),
					{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
					10'($urandom)));
				1: send_req(mk_req(ACT_FINISH, 20'($urandom), 1'($urandom), 0, 0, 0, 0,
					10'($urandom)));
				default: send_req(mk_req(ACT_LOAD, rand_order(), 1'($urandom), 0, rand_cplx(),
					rand_cplx(), rand_cplx(), 10'($urandom)));
			endcase
		end
		send_req(mk_req(ACT_FINISH, 0, 0, 0, 0, 0, 0, 0));
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0)
				send_req(mk_req(ACT_READ, 20'($urandom), 1'($urandom), 1'($urandom), 0, 0, 0,
					10'($urandom)));
			else
				send_req(mk_req(ACT_READ, 0, 1'($urandom), 0, 0, 0, 0,
					10'($urandom_range(0, used_n + 1))));
		end
	endtask

	task automatic fill_table();
		drain();
		write_step(1);
		send_req(mk_req(ACT_LOAD, 0, 0, 1, {$urandom | 1, $urandom}, 0, 64'h1, 0));
		for (int i = 0; i < 345; i++)
			send_req(mk_req(ACT_LOAD, 20'(3 * i + 1), 1'($urandom), 0,
				{$urandom, $urandom | 1}, {$urandom, $urandom | 1}, {$urandom, $urandom | 1}, 0));
		send_req(mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 10'd1023));
		send_req(mk_req(ACT_READ, 0, 1, 0, 0, 0, 0, 10'd1023));
		send_req(mk_req(ACT_READ, 0, 1, 0, 0, 0, 0, 10'd512));
	endtask

	// one long receiver hold once the run is under way
	always @(posedge clk) begin
		if (!held && got >= 300) begin
			held <= 1'b1;
			hold_n <= LONG_HOLD;
		end else if (hold_n > 0) begin
			hold_n <= hold_n - 1;
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (shifted_q.size() == 0) begin
				$error("unexpected result transaction");
				fail_count++;
			end else begin
				e = shifted_q.pop_front();
				if (rsp_ch.out_order !== e.out_order) begin
					$error("out_order exp %0h got %0h", e.out_order, rsp_ch.out_order);
					fail_count++;
				end
				if (rsp_ch.out_f_re !== e.out_f_re) begin
					$error("out_f_re exp %0h got %0h", e.out_f_re, rsp_ch.out_f_re);
					fail_count++;
				end
				if (rsp_ch.out_f_im !== e.out_f_im) begin
					$error("out_f_im exp %0h got %0h", e.out_f_im, rsp_ch.out_f_im);
					fail_count++;
				end
				if (rsp_ch.out_fs_re !== e.out_fs_re) begin
					$error("out_fs_re exp %0h got %0h", e.out_fs_re, rsp_ch.out_fs_re);
					fail_count++;
				end
				if (rsp_ch.out_fs_im !== e.out_fs_im) begin
					$error("out_fs_im exp %0h got %0h", e.out_fs_im, rsp_ch.out_fs_im);
					fail_count++;
				end
				if (rsp_ch.out_z_re !== e.out_z_re) begin
					$error("out_z_re exp %0h got %0h", e.out_z_re, rsp_ch.out_z_re);
					fail_count++;
				end
				if (rsp_ch.out_z_im !== e.out_z_im) begin
					$error("out_z_im exp %0h got %0h", e.out_z_im, rsp_ch.out_z_im);
					fail_count++;
				end
				if (rsp_ch.entry_count !== e.entry_count) begin
					$error("entry_count exp %0d got %0d", e.entry_count, rsp_ch.entry_count);
					fail_count++;
				end
				if (rsp_ch.overflow !== e.overflow) begin
					$error("overflow exp %0b got %0b", e.overflow, rsp_ch.overflow);
					fail_count++;
				end
			end
			got++;
		end
		if (hold_n > 0) begin
			rsp_ch.ready <= 1'b0;
		end else if (stall > 0) begin
			stall--;
			rsp_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall = $urandom_range(0, 2);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		drow_t tbl [$];
		drow_t d;
		res_t idle_res;
		int phase;
		bit filled;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_LOAD;
		req_ch.order = '0;
		req_ch.pool = 1'b0;
		req_ch.echo_row = 1'b0;
		req_ch.f_re = '0;
		req_ch.f_im = '0;
		req_ch.fs_re = '0;
		req_ch.fs_im = '0;
		req_ch.z_re = '0;
		req_ch.z_im = '0;
		req_ch.index = '0;
		clear_table();
		step_q = 0;
		phase = 0;
		filled = 0;

		idle_res = '0;
		idle_res.entry_count = 11'd1;
		d.typed = 1;
		d.exp = idle_res;
		d.stp = 0;
		d.r = mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0); tbl.push_back(d);
		d.r = mk_req(ACT_NONE, ORD_MAX, 1, 1, '1, '1, '1, '1); tbl.push_back(d);
		d.r = mk_req(ACT_FINISH, 0, 0, 0, 0, 0, 0, 0); tbl.push_back(d);
		d.typed = 0;
		d.r = mk_req(ACT_LOAD, 20'd7, 0, 0, 64'h5, 0, 0, 0); tbl.push_back(d);
		d.r = mk_req(ACT_LOAD, 20'd12345, 0, 1, 0, 0, 0, 0); tbl.push_back(d);
		d.r = mk_req(ACT_LOAD, 20'd5, 1, 0, 0, 0, 0, 0); tbl.push_back(d);
		d.r = mk_req(ACT_LOAD, ORD_MAX, 0, 0, 64'h8000_0000_7FFF_FFFF,
			64'h7FFF_FFFF_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 0); tbl.push_back(d);
		d.r = mk_req(ACT_READ, 0, 1, 0, 0, 0, 0, 10'd1); tbl.push_back(d);
		d.r = mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 10'd2); tbl.push_back(d);
		d.r = mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 10'd1023); tbl.push_back(d);
		d.stp = 3;
		d.r = mk_req(ACT_LOAD, 0, 0, 1, 64'h1_0000_0002, 64'h3, 64'h4_0000_0000, 0);
		tbl.push_back(d);
		d.r = mk_req(ACT_LOAD, 20'd1, 0, 0, 64'h8000_0000_0000_0001,
			64'h8000_0000_0000_0009, 0, 0); tbl.push_back(d);
		d.r = mk_req(ACT_LOAD, 20'd2, 1, 0, 0, 0, 64'h7, 0); tbl.push_back(d);
		d.r = mk_req(ACT_FINISH, 0, 0, 0, 0, 0, 0, 0); tbl.push_back(d);
		for (int i = 0; i < 5; i++) begin
			d.r = mk_req(ACT_READ, 0, i[0], 0, 0, 0, 0, 10'(i)); tbl.push_back(d);
		end
		d.stp = 21'sd1048575;
		d.r = mk_req(ACT_LOAD, 0, 0, 1, 0, 0, 0, 0); tbl.push_back(d);
		d.r = mk_req(ACT_LOAD, ORD_MAX, 0, 0, 64'h11, 64'h22, 0, 0); tbl.push_back(d);
		d.r = mk_req(ACT_READ, 0, 0, 0, 0, 0, 0, 10'd1); tbl.push_back(d);
		d.stp = -21'sd1048575;
		d.r = mk_req(ACT_LOAD, 0, 1, 1, 64'h8000_0000_0000_0033, 0, 0, 0); tbl.push_back(d);
		d.r = mk_req(ACT_FINISH, 0, 0, 0, 0, 0, 0, 0); tbl.push_back(d);
		d.r = mk_req(ACT_READ, 0, 1, 0, 0, 0, 0, 10'd0); tbl.push_back(d);
		d.r = mk_req(ACT_READ, 0, 1, 0, 0, 0, 0, 10'd1); tbl.push_back(d);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tbl[i]) begin
			if (tbl[i].stp != step_q) begin
				drain();
				write_step(tbl[i].stp);
			end
			send_req(tbl[i].r, tbl[i].typed, tbl[i].exp);
		end

		while (sent < N_ITEMS) begin
			if (sent >= CALM_AT) calm = 1;
			phase++;
			if (phase == 4 && !filled) begin
				filled = 1;
				fill_table();
			end
			drain();
			write_step(rand_step());
			repeat ($urandom_range(2, 6)) run_pass();
		end

		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && shifted_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
